// ===== sv/assert_macros.svh =====
// Assertion macros shared by the breakpoint comparator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/bcm_pkg.sv =====
// Shared types and constants of the breakpoint comparator manager.
package bcm_pkg;

	localparam int NUM_COMPARATORS_DEF = 8;
	localparam int SLOT_W = 3;

	localparam logic [31:0] ADDR_MASK  = 32'h3FFF_FFFC;
	localparam logic [31:0] CODE_MASK  = 32'hC000_0000;
	localparam logic [31:0] ENABLE_BIT = 32'h0000_0001;
	localparam logic [31:0] HALF_SEL   = 32'h0000_0002;
	localparam logic [1:0]  CODE_LOWER = 2'b01;
	localparam logic [1:0]  CODE_UPPER = 2'b10;
	localparam int          CODE_LSB   = 30;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] bp_address;
	} bcm_req_t;

	typedef struct packed {
		logic              success;
		logic [SLOT_W-1:0] slot_index;
		logic              unit_enabled;
	} bcm_res_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic wr_or;
		logic wr_new;
		logic wr_clr;
		logic record;
	} bcm_cmd_t;

	typedef struct packed {
		logic match;
		logic free;
		logic last;
	} bcm_stat_t;

endpackage

// ===== sv/breakpoint_comparator_manager_core.sv =====
// Top level of the breakpoint comparator manager: sequencer plus table datapath.
//
//  channel   direction  handshake               word
//  request   in         start high, busy low    req (operation, bp_address)
//  result    out        done strobe, one cycle  res (success, slot_index, unit_enabled)
//
// One request is in flight at a time; busy stays high from the accept edge
// until the cycle after the done strobe. One shared comparator walks the
// table one entry per cycle. A set first looks for an entry whose word
// address matches and ORs its code in; failing that it walks again from
// entry 0 and writes the first free entry, and a full table is left as is.
// A clear walks every entry and strips the code from each match.
// arst_n clears every comparator word and the unit enable flag at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module breakpoint_comparator_manager_core #(
	parameter int NUM_COMPARATORS = bcm_pkg::NUM_COMPARATORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bcm_pkg::bcm_req_t req,
	output logic              done,
	output bcm_pkg::bcm_res_t res
);
	import bcm_pkg::*;

	bcm_cmd_t  cmd;
	bcm_stat_t stat;

	// Sequencer: decides which entry to test next and when to write it back.
	bcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.operation),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: holds the table, the captured request and the result word.
	bcm_datapath #(
		.NUM_COMPARATORS (NUM_COMPARATORS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

	// The strobe only comes while the block is still marked busy.
	`ASSERT_SAME(a_done_busy, clk, arst_n, done, busy)
	// An accepted request makes the block busy on the next cycle.
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	// Each result is shown for one cycle only.
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	// A failed request reports slot zero.
	`ASSERT_SAME(a_fail_slot, clk, arst_n, done && !res.success, res.slot_index == '0)
	// Only one kind of table write per cycle.
	`ASSERT_SAME(a_one_write, clk, arst_n, cmd.wr_or || cmd.wr_new || cmd.wr_clr,
		$onehot({cmd.wr_or, cmd.wr_new, cmd.wr_clr}))

endmodule

// ===== sv/bcm_datapath.sv =====
// Comparator table, request registers and result registers.
module bcm_datapath #(
	parameter int NUM_COMPARATORS = bcm_pkg::NUM_COMPARATORS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bcm_pkg::bcm_req_t req,
	input  bcm_pkg::bcm_cmd_t cmd,
	output bcm_pkg::bcm_stat_t stat,
	output bcm_pkg::bcm_res_t res
);
	import bcm_pkg::*;

	localparam int IW = (NUM_COMPARATORS > 1) ? $clog2(NUM_COMPARATORS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_COMPARATORS - 1);

	logic [31:0]       entry_q [NUM_COMPARATORS];
	logic [IW-1:0]     idx_q;
	logic [31:0]       waddr_q;
	logic [31:0]       code_bits_q;
	logic              ok_q;
	logic [SLOT_W-1:0] slot_q;
	logic              unit_q;

	logic [31:0] cur;
	logic [31:0] cleared;
	logic [31:0] code_bits_d;

	assign cur = entry_q[idx_q];
	assign code_bits_d = {((req.bp_address & HALF_SEL) != 32'd0) ? CODE_UPPER : CODE_LOWER,
		30'd0};
	assign cleared = ((cur & ~code_bits_q & CODE_MASK) == 32'd0) ? 32'd0
		: (cur & ~code_bits_q);

	assign stat.match = ((cur & ADDR_MASK) == waddr_q);
	assign stat.free  = ((cur & ENABLE_BIT) == 32'd0);
	assign stat.last  = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMPARATORS; i++) begin
				entry_q[i] <= 32'd0;
			end
		end else if (cmd.wr_or) begin
			entry_q[idx_q] <= cur | ENABLE_BIT | code_bits_q;
		end else if (cmd.wr_new) begin
			entry_q[idx_q] <= waddr_q | ENABLE_BIT | code_bits_q;
		end else if (cmd.wr_clr) begin
			entry_q[idx_q] <= cleared;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			unit_q <= 1'b0;
			ok_q   <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.load) begin
				ok_q   <= 1'b0;
				slot_q <= '0;
				if (req.operation == OP_SET) begin
					unit_q <= 1'b1;
				end
			end else if (cmd.record && !ok_q) begin
				ok_q   <= 1'b1;
				slot_q <= SLOT_W'(idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			waddr_q     <= req.bp_address & ADDR_MASK;
			code_bits_q <= code_bits_d;
		end
	end

	assign res.success      = ok_q;
	assign res.slot_index   = slot_q;
	assign res.unit_enabled = unit_q;

endmodule

// ===== sv/bcm_ctrl.sv =====
// Sequencer that walks the comparator table for one request.
module bcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               op,
	input  bcm_pkg::bcm_stat_t stat,
	output bcm_pkg::bcm_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import bcm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MATCH = 3'd1;
	localparam logic [2:0] ST_FREE  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = (op == OP_SET) ? ST_MATCH : ST_CLEAR;
				end
			end
			ST_MATCH: begin
				if (stat.match) begin
					cmd.wr_or  = 1'b1;
					cmd.record = 1'b1;
					state_d    = ST_DONE;
				end else if (stat.last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_FREE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_FREE: begin
				if (stat.free) begin
					cmd.wr_new = 1'b1;
					cmd.record = 1'b1;
					state_d    = ST_DONE;
				end else if (stat.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_CLEAR: begin
				cmd.wr_clr  = stat.match;
				cmd.record  = stat.match;
				if (stat.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the breakpoint comparator manager core.
`timescale 1ns / 100ps

module testbench;
	import bcm_pkg::*;

	localparam int NUM_CMP     = NUM_COMPARATORS_DEF;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int TAIL_CYCLES = 2 * NUM_CMP + 8;
	localparam int POOL_SIZE   = 11;
	localparam int RANDOM_ITEMS_PER_PHASE = 450;

	// Track the comparator table and the unit flag, and queue the reply word
	// that each accepted request must produce.
	class bp_table_tracker;
		logic [31:0] cmp_words [NUM_CMP];
		logic        unit_on;
		bcm_res_t    expected_replies [$];
		int          mismatches;
		int          replies_seen;

		function new();
			foreach (cmp_words[i])
				cmp_words[i] = '0;
			unit_on = 1'b0;
			mismatches = 0;
			replies_seen = 0;
		endfunction

		task report(string what, logic [31:0] got_v, logic [31:0] want_v);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at reply %0d: %s got %0h want %0h",
					replies_seen, what, got_v, want_v);
		endtask

		function void note_request(bcm_req_t r);
			logic [31:0] waddr;
			logic [31:0] code_bits;
			bcm_res_t    reply;
			bit          hit;
			waddr = r.bp_address & ADDR_MASK;
			code_bits = ((r.bp_address & HALF_SEL) != 0) ? (32'(CODE_UPPER) << CODE_LSB)
				: (32'(CODE_LOWER) << CODE_LSB);
			reply = '0;
			hit = 1'b0;
			if (r.operation == OP_SET) begin
				unit_on = 1'b1;
				// OR into the first entry whose word address matches, enabled or not
				for (int i = 0; i < NUM_CMP; i++) begin
					if (!hit && (cmp_words[i] & ADDR_MASK) == waddr) begin
						cmp_words[i] |= ENABLE_BIT | code_bits;
						hit = 1'b1;
						reply.slot_index = SLOT_W'(i);
					end
				end
				// else take the first disabled entry; a full table changes nothing
				for (int i = 0; i < NUM_CMP; i++) begin
					if (!hit && (cmp_words[i] & ENABLE_BIT) == 0) begin
						cmp_words[i] = waddr | ENABLE_BIT | code_bits;
						hit = 1'b1;
						reply.slot_index = SLOT_W'(i);
					end
				end
			end else begin
				// strip the code from every match, zero an entry left with no code
				for (int i = 0; i < NUM_CMP; i++) begin
					if ((cmp_words[i] & ADDR_MASK) == waddr) begin
						cmp_words[i] &= ~code_bits;
						if ((cmp_words[i] & CODE_MASK) == 0)
							cmp_words[i] = '0;
						if (!hit) begin
							hit = 1'b1;
							reply.slot_index = SLOT_W'(i);
						end
					end
				end
			end
			reply.success = hit;
			reply.unit_enabled = unit_on;
			expected_replies.push_back(reply);
		endfunction

		task check_reply(bcm_res_t got);
			bcm_res_t want;
			replies_seen++;
			if (expected_replies.size() == 0) begin
				report("reply with no request pending", 32'(got), '0);
			end else begin
				want = expected_replies.pop_front();
				if (got.success !== want.success)
					report("success", 32'(got.success), 32'(want.success));
				if (got.slot_index !== want.slot_index)
					report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
				if (got.unit_enabled !== want.unit_enabled)
					report("unit_enabled", 32'(got.unit_enabled), 32'(want.unit_enabled));
			end
		endtask

		task flush_leftovers();
			while (expected_replies.size() > 0) begin
				report("reply never came", '0, 32'(expected_replies.pop_front()));
			end
		endtask

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	bcm_req_t req;
	logic     done;
	bcm_res_t res;

	int unsigned     cycle_count = 0;
	bp_table_tracker tracker = new();
	logic [31:0]     addr_pool [POOL_SIZE];

	breakpoint_comparator_manager_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Stop a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Sample at the rising edge. Check a finished reply word before noting a new
	// request, since a reply always belongs to an earlier request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_reply(res);
			if (start && !busy)
				tracker.note_request(req);
		end
	end

	// Present one request word at the falling edge and hold it until accepted.
	// Return at the falling edge after the accept, with start still high.
	task send_request(input logic op, input logic [31:0] addr);
		bcm_req_t r;
		logic     taken;
		r.operation = op;
		r.bp_address = addr;
		start <= 1'b1;
		req <= r;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// Drop start for one cycle.
	task idle_cycle();
		start <= 1'b0;
		@(negedge clk);
	endtask

	// Drop start and hold off until every reply word has come back.
	task wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// Refill the address pool: a few word addresses so that sets and clears
	// keep hitting the same entries, the lowest and highest among them.
	task refill_pool();
		addr_pool[0] = '0;
		addr_pool[1] = ADDR_MASK;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom() & ADDR_MASK;
	endtask

	// Mostly pool addresses with random ignored bits and halfword select;
	// one in ten is a fully random address.
	task send_random(input int idle_pct);
		logic        op;
		logic [31:0] addr;
		while ($urandom_range(99) < idle_pct)
			idle_cycle();
		op = ($urandom_range(99) < 55) ? OP_SET : OP_CLEAR;
		if ($urandom_range(9) == 0)
			addr = $urandom();
		else
			addr = addr_pool[$urandom_range(POOL_SIZE - 1)] | ($urandom() & ~ADDR_MASK);
		send_request(op, addr);
		if ($urandom_range(199) == 0)
			wait_drained();
	endtask

	task run_random_phase(input int idle_pct);
		refill_pool();
		for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
			send_random(idle_pct);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: clear on an empty table hits zero entry 0
		send_request(OP_CLEAR, 32'h0000_0000);
		// clear with no match at all
		send_request(OP_CLEAR, 32'h0000_1234);
		// set at word 0 lands on the zero entry that matches, then add the upper half
		send_request(OP_SET, 32'h0000_0000);
		send_request(OP_SET, 32'h0000_0002);
		// high bits and bit 0 are ignored; highest word address goes to a free entry
		send_request(OP_SET, 32'hFFFF_FFFF);
		send_request(OP_SET, 32'hC000_0001);
		// fill the rest of the table
		send_request(OP_SET, 32'h0000_1000);
		send_request(OP_SET, 32'h0000_2002);
		send_request(OP_SET, 32'h0000_3000);
		send_request(OP_SET, 32'h0000_4000);
		send_request(OP_SET, 32'h0000_5002);
		send_request(OP_SET, 32'h0000_6000);
		// table full: nothing taken, unit flag still set
		send_request(OP_SET, 32'h0000_7000);
		// strip the upper half, then the lower half, which zeroes the entry
		send_request(OP_CLEAR, 32'h0000_0002);
		send_request(OP_CLEAR, 32'h4000_0000);
		// the freed entry is taken now
		send_request(OP_SET, 32'h0000_7000);
		// clear of a half that is not set keeps the entry; clearing the set half zeroes it
		send_request(OP_CLEAR, 32'hBFFF_FFFD);
		send_request(OP_CLEAR, 32'h3FFF_FFFE);
		// word 0 now matches the first zero entry, past a live one
		send_request(OP_SET, 32'h0000_0000);
		send_request(OP_CLEAR, 32'h0000_2002);
		send_request(OP_CLEAR, 32'h8000_1000);
		send_request(OP_CLEAR, 32'h7FFF_FFF8);
		wait_drained();

		// Random part: sender idles often, then more, then never
		run_random_phase(22);
		run_random_phase(46);
		run_random_phase(0);

		repeat (TAIL_CYCLES) @(negedge clk);
		tracker.flush_leftovers();
		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
